@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL of the moments core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property, checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/mim_pkg.sv @@
// ----------------------------------------------------------------------------
// mim_pkg
// Shared types and constants of the masked image moments core.
// ----------------------------------------------------------------------------
package mim_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int POS_W         = $clog2(MAX_DIMENSION);
  localparam int DIM_W         = POS_W + 1;

  localparam int PIX_W    = 8;
  localparam int LABEL_W  = 8;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  localparam int COUNT_W  = 25;
  localparam int WSUM_W   = 32;
  localparam int SUM1_W   = 44;
  localparam int SUM2_W   = 56;

  localparam int PROD1_W  = PIX_W + POS_W;
  localparam int PROD2_W  = PROD1_W + POS_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LABEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd3;

  localparam logic [MODE_W-1:0] MODE_INTENSITY_ALL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LABEL_ONE     = 2'd1;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIMENSION);
  localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

  typedef struct packed {
    logic [PIX_W-1:0] weight;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             counted;
    logic             last;
  } mim_item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_ONE;
    end else if (d > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

@@ design/mim_front.sv @@
// ----------------------------------------------------------------------------
// mim_front
// Configuration registers, raster position tracking and pixel weighting.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mim_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [mim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mim_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          accept,
  input  logic [mim_pkg::PIX_W-1:0]     pixel_value,
  input  logic [mim_pkg::LABEL_W-1:0]   pixel_label,
  output mim_pkg::mim_item_t            item
);
  import mim_pkg::*;

  logic [MODE_W-1:0]  weight_mode;
  logic [LABEL_W-1:0] target_label;
  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [POS_W-1:0]   col;
  logic [POS_W-1:0]   row;
  logic [POS_W-1:0]   col_next;
  logic [POS_W-1:0]   row_next;

  logic [DIM_W-1:0] w_lim;
  logic [DIM_W-1:0] h_lim;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;
  logic             match;
  logic             counted;
  logic [PIX_W-1:0] weight;
  logic             row_end;
  logic             last;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode  <= MODE_INTENSITY_ALL;
      target_label <= '0;
      frame_width  <= DIM_MAX;
      frame_height <= DIM_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WEIGHT_MODE:  weight_mode  <= cfg_data[MODE_W-1:0];
        REG_TARGET_LABEL: target_label <= cfg_data[LABEL_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_lim   = clamp_dim(frame_width);
    h_lim   = clamp_dim(frame_height);
    col_inc = {1'b0, col} + DIM_ONE;
    row_inc = {1'b0, row} + DIM_ONE;
    match   = (pixel_label == target_label);
    case (weight_mode)
      MODE_INTENSITY_ALL: begin
        counted = 1'b1;
        weight  = pixel_value;
      end
      MODE_LABEL_ONE: begin
        counted = match;
        weight  = match ? PIX_W'(1) : '0;
      end
      default: begin
        counted = match;
        weight  = match ? pixel_value : '0;
      end
    endcase
    row_end  = !(col_inc < w_lim);
    last     = row_end && !(row_inc < h_lim);
    col_next = row_end ? '0 : col_inc[POS_W-1:0];
    row_next = last ? '0 : (row_end ? row_inc[POS_W-1:0] : row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  assign item.weight  = weight;
  assign item.col     = col;
  assign item.row     = row;
  assign item.counted = counted;
  assign item.last    = last;

  `ASSERT_CLK(a_frame_restart, clk, rst, accept && last |=> col == '0 && row == '0,
              "position not cleared after frame end")

endmodule

@@ design/mim_queue.sv @@
// ----------------------------------------------------------------------------
// mim_queue
// Short FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mim_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mim_pkg::mim_item_t push_item,
  input  logic               pop,
  output mim_pkg::mim_item_t pop_item,
  output logic               empty,
  output logic               full
);
  import mim_pkg::*;

  mim_item_t              entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill;

  assign empty    = (fill == '0);
  assign full     = (fill == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + QUEUE_CNT_W'(1);
        2'b01:   fill <= fill - QUEUE_CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  `ASSERT_CLK(a_no_overflow, clk, rst, full |-> !push, "push into full queue")
  `ASSERT_CLK(a_no_underflow, clk, rst, empty |-> !pop, "pop from empty queue")
  `ASSERT_CLK(a_fill_bound, clk, rst, fill <= QUEUE_CNT_W'(QUEUE_DEPTH),
              "queue fill count out of range")

endmodule

@@ design/mim_back.sv @@
// ----------------------------------------------------------------------------
// mim_back
// Product pipeline and moment accumulators; emits sums at frame end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mim_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  mim_pkg::mim_item_t          in_item,
  output logic                        result_valid,
  output logic [mim_pkg::COUNT_W-1:0] pixel_count,
  output logic [mim_pkg::WSUM_W-1:0]  weight_sum,
  output logic [mim_pkg::SUM1_W-1:0]  sum_x,
  output logic [mim_pkg::SUM1_W-1:0]  sum_y,
  output logic [mim_pkg::SUM2_W-1:0]  sum_xx,
  output logic [mim_pkg::SUM2_W-1:0]  sum_xy,
  output logic [mim_pkg::SUM2_W-1:0]  sum_yy
);
  import mim_pkg::*;

  // stage 1: first products
  logic               p1_valid;
  logic               p1_counted;
  logic               p1_last;
  logic [PIX_W-1:0]   p1_w;
  logic [POS_W-1:0]   p1_x;
  logic [POS_W-1:0]   p1_y;
  logic [PROD1_W-1:0] p1_wx;
  logic [PROD1_W-1:0] p1_wy;

  // stage 2: second products
  logic               p2_valid;
  logic               p2_counted;
  logic               p2_last;
  logic [PIX_W-1:0]   p2_w;
  logic [PROD1_W-1:0] p2_wx;
  logic [PROD1_W-1:0] p2_wy;
  logic [PROD2_W-1:0] p2_wxx;
  logic [PROD2_W-1:0] p2_wxy;
  logic [PROD2_W-1:0] p2_wyy;

  logic [COUNT_W-1:0] count_acc;
  logic [WSUM_W-1:0]  weight_acc;
  logic [SUM1_W-1:0]  x_acc;
  logic [SUM1_W-1:0]  y_acc;
  logic [SUM2_W-1:0]  xx_acc;
  logic [SUM2_W-1:0]  xy_acc;
  logic [SUM2_W-1:0]  yy_acc;

  logic [COUNT_W-1:0] count_next;
  logic [WSUM_W-1:0]  weight_next;
  logic [SUM1_W-1:0]  x_next;
  logic [SUM1_W-1:0]  y_next;
  logic [SUM2_W-1:0]  xx_next;
  logic [SUM2_W-1:0]  xy_next;
  logic [SUM2_W-1:0]  yy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= in_valid;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_counted <= in_item.counted;
    p1_last    <= in_item.last;
    p1_w       <= in_item.weight;
    p1_x       <= in_item.col;
    p1_y       <= in_item.row;
    p1_wx      <= PROD1_W'(in_item.weight) * PROD1_W'(in_item.col);
    p1_wy      <= PROD1_W'(in_item.weight) * PROD1_W'(in_item.row);

    p2_counted <= p1_counted;
    p2_last    <= p1_last;
    p2_w       <= p1_w;
    p2_wx      <= p1_wx;
    p2_wy      <= p1_wy;
    p2_wxx     <= PROD2_W'(p1_wx) * PROD2_W'(p1_x);
    p2_wxy     <= PROD2_W'(p1_wx) * PROD2_W'(p1_y);
    p2_wyy     <= PROD2_W'(p1_wy) * PROD2_W'(p1_y);
  end

  // weight is zero for pixels that are not counted
  always_comb begin
    count_next  = count_acc + COUNT_W'(p2_counted);
    weight_next = weight_acc + WSUM_W'(p2_w);
    x_next      = x_acc + SUM1_W'(p2_wx);
    y_next      = y_acc + SUM1_W'(p2_wy);
    xx_next     = xx_acc + SUM2_W'(p2_wxx);
    xy_next     = xy_acc + SUM2_W'(p2_wxy);
    yy_next     = yy_acc + SUM2_W'(p2_wyy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_acc  <= '0;
      weight_acc <= '0;
      x_acc      <= '0;
      y_acc      <= '0;
      xx_acc     <= '0;
      xy_acc     <= '0;
      yy_acc     <= '0;
    end else if (p2_valid) begin
      if (p2_last) begin
        count_acc  <= '0;
        weight_acc <= '0;
        x_acc      <= '0;
        y_acc      <= '0;
        xx_acc     <= '0;
        xy_acc     <= '0;
        yy_acc     <= '0;
      end else begin
        count_acc  <= count_next;
        weight_acc <= weight_next;
        x_acc      <= x_next;
        y_acc      <= y_next;
        xx_acc     <= xx_next;
        xy_acc     <= xy_next;
        yy_acc     <= yy_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= p2_valid && p2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_valid && p2_last) begin
      pixel_count <= count_next;
      weight_sum  <= weight_next;
      sum_x       <= x_next;
      sum_y       <= y_next;
      sum_xx      <= xx_next;
      sum_xy      <= xy_next;
      sum_yy      <= yy_next;
    end
  end

  `ASSERT_CLK(a_last_travels, clk, rst, p1_valid && p1_last |=> p2_valid && p2_last,
              "frame end lost between product stages")
  `ASSERT_CLK(a_clear_on_result, clk, rst, result_valid |-> count_acc == '0,
              "accumulators not cleared with result")

endmodule

@@ design/masked_image_moments_core.sv @@
// ----------------------------------------------------------------------------
// masked_image_moments_core
// Raw image moments up to second order over a raster pixel stream.
//
// Channel  Direction  Handshake                 Payload
// pixel    in         start / busy              pixel_value, pixel_label
// cfg      in         cfg_valid / cfg_ready     cfg_index, cfg_data
// result   out        result_valid (strobe)     pixel_count .. sum_yy
//
// One pixel per clock; the back end never stalls, so busy stays low in use.
// The frame's result strobe follows its last taken pixel through the queue,
// the two multiplier stages, then the registered accumulator sums.
// Synchronous reset clears position, sums and registers (width/height 4096).
// Results cannot be held off; each is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module masked_image_moments_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [mim_pkg::PIX_W-1:0]      pixel_value,
  input  logic [mim_pkg::LABEL_W-1:0]    pixel_label,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mim_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           result_valid,
  output logic [mim_pkg::COUNT_W-1:0]    pixel_count,
  output logic [mim_pkg::WSUM_W-1:0]     weight_sum,
  output logic [mim_pkg::SUM1_W-1:0]     sum_x,
  output logic [mim_pkg::SUM1_W-1:0]     sum_y,
  output logic [mim_pkg::SUM2_W-1:0]     sum_xx,
  output logic [mim_pkg::SUM2_W-1:0]     sum_xy,
  output logic [mim_pkg::SUM2_W-1:0]     sum_yy
);
  import mim_pkg::*;

  mim_item_t front_item;
  mim_item_t queue_item;
  logic      accept;
  logic      queue_empty;
  logic      queue_full;
  logic      pop;

  assign cfg_ready = 1'b1;
  assign busy      = queue_full;
  assign accept    = start && !queue_full;
  assign pop       = !queue_empty;

  mim_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .pixel_value (pixel_value),
    .pixel_label (pixel_label),
    .item        (front_item)
  );

  mim_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .pop       (pop),
    .pop_item  (queue_item),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  mim_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pop),
    .in_item      (queue_item),
    .result_valid (result_valid),
    .pixel_count  (pixel_count),
    .weight_sum   (weight_sum),
    .sum_x        (sum_x),
    .sum_y        (sum_y),
    .sum_xx       (sum_xx),
    .sum_xy       (sum_xy),
    .sum_yy       (sum_yy)
  );

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for masked_image_moments_core.
//
// A directed table (reset dimensions, single-pixel frames, each weight mode,
// dimension clamping, unused register indexes, mid-frame width change) runs
// first, then randomized frames under three pacing profiles. Every pixel
// transaction steps a local moments model; each frame-end strobe is checked
// field by field.
// ----------------------------------------------------------------------------
module tb;
  import mim_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 230;

  localparam logic [MODE_W-1:0]     MODE_INTENSITY_MATCH = 2'd2;
  localparam logic [MODE_W-1:0]     MODE_SPARE           = 2'd3;
  localparam logic [CFG_IDX_W-1:0]  REG_UNUSED_LOW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0]  REG_UNUSED_HIGH      = 3'd7;
  localparam logic [CFG_DATA_W-1:0] DIM_ALL_ONES         = '1;

  typedef struct packed {
    logic [COUNT_W-1:0] pixel_count;
    logic [WSUM_W-1:0]  weight_sum;
    logic [SUM1_W-1:0]  sum_x;
    logic [SUM1_W-1:0]  sum_y;
    logic [SUM2_W-1:0]  sum_xx;
    logic [SUM2_W-1:0]  sum_xy;
    logic [SUM2_W-1:0]  sum_yy;
  } moments_t;

  typedef enum logic {ROW_REG_WRITE, ROW_PIXEL} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [PIX_W-1:0]      value;
    logic [LABEL_W-1:0]    label;
    bit                    has_total;
    moments_t              total;
  } plan_row_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  start        = 1'b0;
  logic                  busy;
  logic [PIX_W-1:0]      pixel_value  = '0;
  logic [LABEL_W-1:0]    pixel_label  = '0;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  result_valid;
  logic [COUNT_W-1:0]    pixel_count;
  logic [WSUM_W-1:0]     weight_sum;
  logic [SUM1_W-1:0]     sum_x;
  logic [SUM1_W-1:0]     sum_y;
  logic [SUM2_W-1:0]     sum_xx;
  logic [SUM2_W-1:0]     sum_xy;
  logic [SUM2_W-1:0]     sum_yy;

  // typed frame total riding along with a directed pixel
  bit       pix_typed = 1'b0;
  moments_t pix_want  = '0;

  logic [MODE_W-1:0]     cur_mode;
  logic [LABEL_W-1:0]    cur_target;
  logic [CFG_DATA_W-1:0] cur_width;
  logic [CFG_DATA_W-1:0] cur_height;
  logic [POS_W-1:0]      col_pos;
  logic [POS_W-1:0]      row_pos;
  moments_t              running;

  moments_t    expected_frames[$];
  plan_row_t   plan[$];
  logic [LABEL_W-1:0] drv_target = '0;
  int unsigned idle_pct       = 0;
  int unsigned pixels_sent    = 0;
  int unsigned pixels_seen    = 0;
  int unsigned frames_checked = 0;
  int unsigned reg_writes     = 0;
  int unsigned fail_count     = 0;
  int unsigned stall_cycles   = 0;

  masked_image_moments_core dut (.*);

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic logic [CFG_DATA_W-1:0] limit_dim(input logic [CFG_DATA_W-1:0] d);
    if (d == '0) begin
      return CFG_DATA_W'(1);
    end else if (d > CFG_DATA_W'(MAX_DIMENSION)) begin
      return CFG_DATA_W'(MAX_DIMENSION);
    end
    return d;
  endfunction

  task automatic accumulate_pixel(input logic [PIX_W-1:0] value,
                                  input logic [LABEL_W-1:0] label,
                                  output bit frame_done, output moments_t totals);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] w;
    logic [63:0] wx;
    logic [63:0] wy;
    bit          counted;
    x = 64'(col_pos);
    y = 64'(row_pos);
    counted = (cur_mode == MODE_INTENSITY_ALL) || (label == cur_target);
    w = (cur_mode == MODE_LABEL_ONE) ? 64'd1 : 64'(value);
    wx = w * x;
    wy = w * y;
    frame_done = 1'b0;
    totals = '0;
    if (counted) begin
      running.pixel_count = running.pixel_count + 1'b1;
      running.weight_sum  = running.weight_sum + WSUM_W'(w);
      running.sum_x       = running.sum_x + SUM1_W'(wx);
      running.sum_y       = running.sum_y + SUM1_W'(wy);
      running.sum_xx      = running.sum_xx + SUM2_W'(wx * x);
      running.sum_xy      = running.sum_xy + SUM2_W'(wx * y);
      running.sum_yy      = running.sum_yy + SUM2_W'(wy * y);
    end
    if (x + 64'd1 < 64'(limit_dim(cur_width))) begin
      col_pos = col_pos + 1'b1;
    end else if (y + 64'd1 < 64'(limit_dim(cur_height))) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      frame_done = 1'b1;
      totals = running;
      col_pos = '0;
      row_pos = '0;
      running = '0;
    end
  endtask

  task automatic compare_moments(input moments_t want, input moments_t got);
    if (got.pixel_count !== want.pixel_count) begin
      $error("pixel_count: expected %0d, actual %0d", want.pixel_count, got.pixel_count);
      fail_count++;
    end
    if (got.weight_sum !== want.weight_sum) begin
      $error("weight_sum: expected %0d, actual %0d", want.weight_sum, got.weight_sum);
      fail_count++;
    end
    if (got.sum_x !== want.sum_x) begin
      $error("sum_x: expected %0d, actual %0d", want.sum_x, got.sum_x);
      fail_count++;
    end
    if (got.sum_y !== want.sum_y) begin
      $error("sum_y: expected %0d, actual %0d", want.sum_y, got.sum_y);
      fail_count++;
    end
    if (got.sum_xx !== want.sum_xx) begin
      $error("sum_xx: expected %0d, actual %0d", want.sum_xx, got.sum_xx);
      fail_count++;
    end
    if (got.sum_xy !== want.sum_xy) begin
      $error("sum_xy: expected %0d, actual %0d", want.sum_xy, got.sum_xy);
      fail_count++;
    end
    if (got.sum_yy !== want.sum_yy) begin
      $error("sum_yy: expected %0d, actual %0d", want.sum_yy, got.sum_yy);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : observe
    moments_t totals;
    moments_t seen;
    bit       frame_done;
    bit       moved;
    if (rst) begin
      cur_mode     = MODE_INTENSITY_ALL;
      cur_target   = '0;
      cur_width    = CFG_DATA_W'(MAX_DIMENSION);
      cur_height   = CFG_DATA_W'(MAX_DIMENSION);
      col_pos      = '0;
      row_pos      = '0;
      running      = '0;
      stall_cycles = 0;
    end else begin
      moved = 1'b0;
      if (result_valid === 1'b1) begin
        moved = 1'b1;
        frames_checked++;
        seen = '{pixel_count, weight_sum, sum_x, sum_y, sum_xx, sum_xy, sum_yy};
        if (expected_frames.size() == 0) begin
          $error("frame result strobed with no frame end pending");
          fail_count++;
        end else begin
          compare_moments(expected_frames.pop_front(), seen);
        end
      end
      if (start && busy === 1'b0) begin
        moved = 1'b1;
        pixels_seen++;
        accumulate_pixel(pixel_value, pixel_label, frame_done, totals);
        if (frame_done) begin
          expected_frames.push_back(pix_typed ? pix_want : totals);
        end
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        moved = 1'b1;
        reg_writes++;
        case (cfg_index)
          REG_WEIGHT_MODE:  cur_mode   = cfg_data[MODE_W-1:0];
          REG_TARGET_LABEL: cur_target = cfg_data[LABEL_W-1:0];
          REG_FRAME_WIDTH:  cur_width  = cfg_data;
          REG_FRAME_HEIGHT: cur_height = cfg_data;
          default: ;
        endcase
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", stall_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_frames.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    if (index == REG_TARGET_LABEL) begin
      drv_target = data[LABEL_W-1:0];
    end
  endtask

  task automatic drive_pixel(input logic [PIX_W-1:0] value, input logic [LABEL_W-1:0] label,
                             input bit typed, input moments_t want);
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    pixel_value <= value;
    pixel_label <= label;
    pix_typed   <= typed;
    pix_want    <= want;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pixels_sent++;
  endtask

  function automatic logic [PIX_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return PIX_W'($urandom);
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label();
    return ($urandom_range(1) == 1) ? drv_target : LABEL_W'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim(input int unsigned top);
    return ($urandom_range(9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, top));
  endfunction

  task automatic run_random(input int unsigned items);
    int unsigned goal;
    int unsigned burst;
    goal = pixels_sent + items;
    while (pixels_sent < goal) begin
      if ($urandom_range(99) < 40) write_reg(REG_WEIGHT_MODE, CFG_DATA_W'($urandom_range(3)));
      if ($urandom_range(99) < 40) write_reg(REG_TARGET_LABEL, CFG_DATA_W'($urandom_range(255)));
      if ($urandom_range(99) < 40) write_reg(REG_FRAME_WIDTH, pick_dim(6));
      if ($urandom_range(99) < 40) write_reg(REG_FRAME_HEIGHT, pick_dim(5));
      if ($urandom_range(99) < 5) begin
        write_reg(REG_UNUSED_LOW + CFG_IDX_W'($urandom_range(3)), CFG_DATA_W'($urandom));
      end
      burst = $urandom_range(1, 40);
      repeat (burst) drive_pixel(pick_value(), pick_label(), 1'b0, '0);
    end
  endtask

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] index,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '{ROW_REG_WRITE, index, data, '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t pix_row(input logic [PIX_W-1:0] value,
                                        input logic [LABEL_W-1:0] label);
    plan_row_t r;
    r = '{ROW_PIXEL, '0, '0, value, label, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t pix_total(input logic [PIX_W-1:0] value,
                                          input logic [LABEL_W-1:0] label,
                                          input moments_t want);
    plan_row_t r;
    r = '{ROW_PIXEL, '0, '0, value, label, 1'b1, want};
    return r;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    plan = '{
      pix_row(8'd10, 8'h5A),
      pix_row(8'd20, 8'hA5),
      cfg_row(REG_FRAME_WIDTH, CFG_DATA_W'(1)),
      cfg_row(REG_FRAME_HEIGHT, CFG_DATA_W'(1)),
      pix_total(8'd30, 8'h00, '{25'd3, 32'd60, 44'd80, 44'd0, 56'd140, 56'd0, 56'd0}),
      pix_total(8'hFF, 8'hFF, '{25'd1, 32'd255, 44'd0, 44'd0, 56'd0, 56'd0, 56'd0}),
      pix_total(8'h00, 8'h00, '{25'd1, 32'd0, 44'd0, 44'd0, 56'd0, 56'd0, 56'd0}),
      cfg_row(REG_WEIGHT_MODE, CFG_DATA_W'(MODE_LABEL_ONE)),
      cfg_row(REG_TARGET_LABEL, CFG_DATA_W'(255)),
      pix_total(8'h00, 8'hFF, '{25'd1, 32'd1, 44'd0, 44'd0, 56'd0, 56'd0, 56'd0}),
      pix_total(8'hFF, 8'hFE, '0),
      cfg_row(REG_WEIGHT_MODE, CFG_DATA_W'(MODE_SPARE)),
      cfg_row(REG_TARGET_LABEL, CFG_DATA_W'(0)),
      pix_total(8'hFF, 8'h00, '{25'd1, 32'd255, 44'd0, 44'd0, 56'd0, 56'd0, 56'd0}),
      pix_total(8'd200, 8'h01, '0),
      cfg_row(REG_WEIGHT_MODE, CFG_DATA_W'(MODE_INTENSITY_ALL)),
      cfg_row(REG_FRAME_WIDTH, CFG_DATA_W'(0)),
      cfg_row(REG_FRAME_HEIGHT, CFG_DATA_W'(2)),
      pix_row(8'hFF, 8'h07),
      pix_total(8'hFF, 8'h09, '{25'd2, 32'd510, 44'd0, 44'd255, 56'd0, 56'd0, 56'd255}),
      cfg_row(REG_UNUSED_LOW, DIM_ALL_ONES),
      cfg_row(REG_UNUSED_HIGH, '0),
      cfg_row(REG_WEIGHT_MODE, CFG_DATA_W'(MODE_INTENSITY_MATCH)),
      cfg_row(REG_TARGET_LABEL, CFG_DATA_W'(7)),
      cfg_row(REG_FRAME_WIDTH, CFG_DATA_W'(3)),
      pix_row(8'd9, 8'd7),
      pix_row(8'd100, 8'd6),
      pix_row(8'd255, 8'd7),
      pix_row(8'd1, 8'd7),
      pix_row(8'd50, 8'd0),
      pix_row(8'd77, 8'd7),
      cfg_row(REG_WEIGHT_MODE, CFG_DATA_W'(MODE_INTENSITY_ALL)),
      cfg_row(REG_FRAME_WIDTH, CFG_DATA_W'(4)),
      cfg_row(REG_FRAME_HEIGHT, CFG_DATA_W'(3)),
      pix_row(8'd1, 8'd0),
      pix_row(8'd2, 8'd0),
      pix_row(8'd3, 8'd0),
      // width shrinks below the current column
      cfg_row(REG_FRAME_WIDTH, CFG_DATA_W'(2)),
      pix_row(8'd4, 8'd0),
      pix_row(8'd5, 8'd0),
      pix_row(8'd6, 8'd0),
      pix_row(8'd7, 8'd0),
      pix_row(8'd8, 8'd0)
    };

    idle_pct = 27;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG_WRITE) begin
        write_reg(plan[i].reg_index, plan[i].reg_data);
      end else begin
        drive_pixel(plan[i].value, plan[i].label, plan[i].has_total, plan[i].total);
      end
    end
    run_random(PHASE_ITEMS);

    idle_pct = 77;
    run_random(PHASE_ITEMS);

    idle_pct = 0;
    run_random(PHASE_ITEMS);

    // close any open frame
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(1));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
    drive_pixel(pick_value(), pick_label(), 1'b0, '0);

    wait_drained();
    $display("Covered %0d pixels, %0d frame results and %0d register writes,",
             pixels_seen, frames_checked, reg_writes);
    $display("all weight modes, clamped and shrinking dimensions, three pacing profiles.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
